@@ rtl/rlbe_pkg.sv @@
package rlbe_pkg;

  localparam logic [5:0] RUN_MAX    = 6'd63;
  localparam logic [7:0] COUNT_MARK = 8'hC0;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       burst_last;
    logic       line_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] len;
  } run_t;

  // One entry per item that closes runs: a is the run the new byte ends,
  // b is the run that the line end ends (present exactly on line end).
  typedef struct packed {
    logic a_valid;
    run_t a;
    logic b_valid;
    run_t b;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_A_HEAD,
    PH_A_VAL,
    PH_B_HEAD,
    PH_B_VAL
  } phase_t;

endpackage

@@ rtl/rlbe_front.sv @@
module rlbe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rlbe_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output rlbe_pkg::cmd_t    q_cmd
);

  logic [7:0] run_byte_r, run_byte_nxt;
  logic [5:0] run_len_r, run_len_nxt;
  logic       run_open_r, run_open_nxt;
  logic       accept;
  logic       extend;
  rlbe_pkg::run_t new_run;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    extend = run_open_r && (in_item.pixel == run_byte_r) && (run_len_r < rlbe_pkg::RUN_MAX);
    if (extend) begin
      new_run.value = run_byte_r;
      new_run.len   = run_len_r + 6'd1;
    end else begin
      new_run.value = in_item.pixel;
      new_run.len   = 6'd1;
    end

    q_cmd.a_valid = run_open_r && !extend;
    q_cmd.a.value = run_byte_r;
    q_cmd.a.len   = run_len_r;
    q_cmd.b_valid = in_item.line_end;
    q_cmd.b       = new_run;
    q_push        = accept && (q_cmd.a_valid || q_cmd.b_valid);

    run_byte_nxt = run_byte_r;
    run_len_nxt  = run_len_r;
    run_open_nxt = run_open_r;
    if (accept) begin
      if (in_item.line_end) begin
        // close everything at the line end
        run_byte_nxt = 8'd0;
        run_len_nxt  = 6'd0;
        run_open_nxt = 1'b0;
      end else begin
        run_byte_nxt = new_run.value;
        run_len_nxt  = new_run.len;
        run_open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r <= 8'd0;
      run_len_r  <= 6'd0;
      run_open_r <= 1'b0;
    end else begin
      run_byte_r <= run_byte_nxt;
      run_len_r  <= run_len_nxt;
      run_open_r <= run_open_nxt;
    end
  end

endmodule

@@ rtl/rlbe_queue.sv @@
module rlbe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rlbe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output rlbe_pkg::cmd_t head_cmd
);

  rlbe_pkg::cmd_t                mem_r [rlbe_pkg::QDEPTH];
  logic [rlbe_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rlbe_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rlbe_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == rlbe_pkg::QCNT_W'(rlbe_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
    else $error("command queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("command queue count did not advance on write");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= rlbe_pkg::QCNT_W'(rlbe_pkg::QDEPTH))
    else $error("command queue count out of range");

endmodule

@@ rtl/rlbe_back.sv @@
module rlbe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rlbe_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rlbe_pkg::out_item_t out_item
);

  rlbe_pkg::cmd_t      work_r, work_nxt;
  logic                work_valid_r, work_valid_nxt;
  rlbe_pkg::phase_t    phase_r, phase_nxt;
  logic                out_valid_r, out_valid_nxt;
  rlbe_pkg::out_item_t out_item_r, out_item_nxt;

  logic           out_ready;
  logic           emit;
  logic           in_b;
  logic           head;
  logic           single;
  logic           run_done;
  logic           entry_done;
  rlbe_pkg::run_t cur;
  logic [7:0]     code;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    out_ready = !out_valid_r || !out_stall;
    emit      = work_valid_r && out_ready;
    in_b      = (phase_r inside {rlbe_pkg::PH_B_HEAD, rlbe_pkg::PH_B_VAL});
    head      = (phase_r inside {rlbe_pkg::PH_A_HEAD, rlbe_pkg::PH_B_HEAD});
    cur       = in_b ? work_r.b : work_r.a;
    single    = (cur.len == 6'd1) && (cur.value < rlbe_pkg::COUNT_MARK);
    code      = (head && !single) ? rlbe_pkg::COUNT_MARK + {2'b00, cur.len} : cur.value;
    run_done  = single || !head;
    entry_done = run_done && (in_b || !work_r.b_valid);

    q_pop = q_valid && (!work_valid_r || (emit && entry_done));

    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    phase_nxt      = phase_r;
    if (q_pop) begin
      work_nxt       = q_cmd;
      work_valid_nxt = 1'b1;
      phase_nxt      = q_cmd.a_valid ? rlbe_pkg::PH_A_HEAD : rlbe_pkg::PH_B_HEAD;
    end else if (emit) begin
      if (entry_done) begin
        work_valid_nxt = 1'b0;
      end else begin
        case (phase_r)
          rlbe_pkg::PH_A_HEAD: phase_nxt = run_done ? rlbe_pkg::PH_B_HEAD : rlbe_pkg::PH_A_VAL;
          rlbe_pkg::PH_A_VAL:  phase_nxt = rlbe_pkg::PH_B_HEAD;
          rlbe_pkg::PH_B_HEAD: phase_nxt = rlbe_pkg::PH_B_VAL;
          default:             phase_nxt = phase_r;
        endcase
      end
    end

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_ready) begin
      out_valid_nxt           = emit;
      out_item_nxt.code_byte  = code;
      out_item_nxt.burst_last = entry_done;
      out_item_nxt.line_done  = entry_done && work_r.b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      phase_r      <= rlbe_pkg::PH_A_HEAD;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_item_r <= out_item_nxt;
  end

  a_line_done_last: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_item_r.line_done) |-> out_item_r.burst_last)
    else $error("line_done without burst_last");

endmodule

@@ rtl/run_length_byte_encoder.sv @@
// Run-length byte encoder for scan-line data.
//
// Input channel (in_valid / in_stall / in_item): one pixel byte per item,
// with line_end set on the last byte of a scan line. An item is taken at
// a clock edge with in_valid high and in_stall low. in_stall rises only
// when the internal command queue is full.
// Result channel (out_valid / out_stall / out_item): one code byte per
// item. burst_last marks the last byte caused by one input item,
// line_done the last byte of a scan line. A stalled result holds.
// Each input item causes zero to four code bytes: the run it closes and,
// on line end, the run holding the final byte.
// Throughput: one input item per cycle while the queue has room; the
// output side moves one code byte per cycle while out_stall is low, and
// a lone byte at or above 0xC0 causes two code bytes. The back-end
// serializer sets the sustained rate.
// With the back end idle, an item's command passes from the queue into
// the back end's work register before its first code byte reaches out_valid.
// Reset (rst_n low, synchronous): clears the pending run, the queue and
// the output register; no results are pending afterwards.
module run_length_byte_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlbe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rlbe_pkg::out_item_t out_item
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  rlbe_pkg::cmd_t push_cmd;
  rlbe_pkg::cmd_t head_cmd;

  // Front: track the open run, classify each item into run closures
  rlbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Queue: decouple the classifier from the byte serializer
  rlbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // Back: expand each closure into code bytes, one per cycle while out_stall is low
  rlbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ tb/run_length_byte_encoder_tb.sv @@
`timescale 1ns / 1ps

module run_length_byte_encoder_tb;

  typedef struct {
    rlbe_pkg::in_item_t item;
    bit                 drain;
  } pixel_slot_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  rlbe_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rlbe_pkg::out_item_t out_item;

  // Stimulus waiting to be offered, and code bytes the encoder still owes us
  pixel_slot_t         pending_pixels[$];
  rlbe_pkg::out_item_t expected_codes[$];

  // Shadow of the encoder's open run
  logic [7:0] run_value;
  logic [5:0] run_length;
  logic       run_pending;

  int  n_queued;
  int  drain_mark_a;
  int  drain_mark_b;
  int  items_taken;
  int  mismatches;
  bit  calm;

  run_length_byte_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the encoder wedges or drops bytes
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Append the code bytes for the open run: a lone low byte goes out as
  // itself, anything else as a count byte followed by the value.
  function automatic void emit_run_bytes();
    rlbe_pkg::out_item_t b;
    b = '0;
    if (run_length == 6'd1 && run_value < rlbe_pkg::COUNT_MARK) begin
      b.code_byte = run_value;
      expected_codes.push_back(b);
    end else begin
      b.code_byte = rlbe_pkg::COUNT_MARK + {2'b00, run_length};
      expected_codes.push_back(b);
      b.code_byte = run_value;
      expected_codes.push_back(b);
    end
    run_pending = 1'b0;
  endfunction

  // Advance the shadow run by one accepted pixel and queue the bytes it
  // causes; tag the final one of the burst (and of the line, on line end).
  function automatic void encode_pixel(rlbe_pkg::in_item_t it);
    int                  prior_count;
    rlbe_pkg::out_item_t tail;
    prior_count = expected_codes.size();
    if (run_pending && it.pixel == run_value && run_length < rlbe_pkg::RUN_MAX) begin
      run_length = run_length + 6'd1;
    end else begin
      if (run_pending) emit_run_bytes();
      run_value   = it.pixel;
      run_length  = 6'd1;
      run_pending = 1'b1;
    end
    if (it.line_end) begin
      emit_run_bytes();
      run_value  = '0;
      run_length = '0;
    end
    if (expected_codes.size() > prior_count) begin
      tail = expected_codes.pop_back();
      tail.burst_last = 1'b1;
      if (it.line_end) tail.line_done = 1'b1;
      expected_codes.push_back(tail);
    end
  endfunction

  function automatic void queue_pixel(logic [7:0] px, logic le);
    pixel_slot_t s;
    s.item.pixel    = px;
    s.item.line_end = le;
    s.drain         = (n_queued == drain_mark_a) || (n_queued == drain_mark_b);
    pending_pixels.push_back(s);
    n_queued++;
  endfunction

  // Bias toward the count-mark boundary and the byte extremes
  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_value = 8'($urandom_range(8'hC0, 8'hFF));
      3:       pick_value = $urandom_range(0, 1) ? 8'hBF : 8'hC0;
      4:       pick_value = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: pick_value = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Driver: account for the item taken at this edge, then hold, offer the
  // next one, or idle. Offer with no random gaps for a stretch in the middle of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_pixel(in_item);
        items_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled item as it is
      end else if (pending_pixels.size() > 0
                   && !(pending_pixels[0].drain && expected_codes.size() != 0)
                   && (calm || $urandom_range(0, 99) >= 34)) begin
        in_valid <= 1'b1;
        in_item  <= pending_pixels[0].item;
        void'(pending_pixels.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    calm <= (items_taken >= 120 && items_taken < 190);
  end

  // Monitor: check every byte taken at this edge against the oldest
  // expectation, then pick the stall for the next cycle.
  always @(posedge clk) begin
    rlbe_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected code byte %0h", out_item.code_byte);
        mismatches++;
      end else begin
        want = expected_codes.pop_front();
        if (out_item.code_byte !== want.code_byte) begin
          $error("code_byte: expected %0h, actual %0h", want.code_byte, out_item.code_byte);
          mismatches++;
        end
        if (out_item.burst_last !== want.burst_last) begin
          $error("burst_last: expected %0b, actual %0b", want.burst_last, out_item.burst_last);
          mismatches++;
        end
        if (out_item.line_done !== want.line_done) begin
          $error("line_done: expected %0b, actual %0b", want.line_done, out_item.line_done);
          mismatches++;
        end
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);
  end

  initial begin
    int random_start;
    int n_runs;
    int len;
    logic [7:0] val;

    run_value    = '0;
    run_length   = '0;
    run_pending  = 1'b0;
    n_queued     = 0;
    items_taken  = 0;
    mismatches   = 0;
    calm         = 1'b0;
    drain_mark_a = -1;
    drain_mark_b = -1;

    // Lone bytes that close a line on their own: low value goes out plain,
    // 0xFF needs a count byte.
    queue_pixel(8'h00, 1'b1);
    queue_pixel(8'hFF, 1'b1);
    // Straddle the count mark; a byte change closes the previous run
    queue_pixel(8'hBF, 1'b0);
    queue_pixel(8'hC0, 1'b0);
    queue_pixel(8'hC0, 1'b0);
    queue_pixel(8'h01, 1'b0);
    queue_pixel(8'h01, 1'b1);
    // New byte on line end: two runs close in one step, four bytes out
    queue_pixel(8'hC5, 1'b0);
    queue_pixel(8'hD0, 1'b1);
    // Growing run with no output until the line ends
    queue_pixel(8'h3F, 1'b0);
    queue_pixel(8'h3F, 1'b0);
    queue_pixel(8'h3F, 1'b0);
    queue_pixel(8'h3F, 1'b1);
    queue_pixel(8'h7E, 1'b0);
    queue_pixel(8'h7F, 1'b0);
    queue_pixel(8'h80, 1'b0);
    queue_pixel(8'h80, 1'b1);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h00, 1'b1);
    queue_pixel(8'h12, 1'b0);
    queue_pixel(8'h34, 1'b1);

    // Drain the encoder before the random part and once more halfway in
    random_start = n_queued;
    drain_mark_a = random_start;
    drain_mark_b = random_start + 130;

    // One line that overflows the 63-byte run limit
    val = pick_value();
    len = $urandom_range(64, 70);
    for (int k = 0; k < len; k++) queue_pixel(val, k == len - 1);

    // Mostly well-formed lines built from runs; the rest is noise with line
    // ends anywhere and lines that never close.
    while (n_queued < random_start + 260) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        n_runs = $urandom_range(1, 6);
        for (int r = 0; r < n_runs; r++) begin
          val = pick_value();
          case ($urandom_range(0, 19))
            0:          len = $urandom_range(60, 70);
            1, 2, 3, 4: len = $urandom_range(4, 12);
            default:    len = $urandom_range(1, 3);
          endcase
          for (int k = 0; k < len; k++) queue_pixel(val, r == n_runs - 1 && k == len - 1);
        end
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every code byte to come out,
    // then linger past the pipeline latency to catch strays.
    while (pending_pixels.size() != 0 || in_valid) @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
